// ===== rtl/core/joystick_gimbal_angle_integrator_core_defines.svh =====
// ----------------------------------------------------------------------------
// Joystick gimbal angle integrator assertion macros
// Clocked assertion helpers for the checker file of the core.
// ----------------------------------------------------------------------------
`ifndef JOYSTICK_GIMBAL_ANGLE_INTEGRATOR_CORE_DEFINES_SVH
`define JOYSTICK_GIMBAL_ANGLE_INTEGRATOR_CORE_DEFINES_SVH

// Assertion sampled on the rising clock edge and masked while reset is low.
`define JGAI_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Assertion sampled on the rising clock edge, active during reset too.
`define JGAI_ASSERT_RST(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/core/jgai_pkg.sv =====
// ----------------------------------------------------------------------------
// Joystick gimbal angle integrator package
// Widths, constants, pipeline payload types and the saturating angle update.
// ----------------------------------------------------------------------------
`default_nettype none

package jgai_pkg;

  localparam int SAMPLE_BITS_DEF = 12;
  localparam int CENTER_W        = 12;
  localparam int DEADZONE_W      = 11;
  localparam int SPEED_W         = 16;
  localparam int ELAPSED_W       = 16;
  localparam int CFG_INDEX_W     = 2;
  localparam int CFG_DATA_W      = 16;

  localparam int PAN_W   = 16;
  localparam int TILT_W  = 15;
  localparam int ROLL_W  = 16;
  localparam int MODE_W  = 2;
  localparam int OUT_W   = 56;

  localparam int PROD_W  = SPEED_W + ELAPSED_W;
  localparam int DIV_PRE = 3;
  localparam int RECIP_W = 30;
  localparam int DIV_SHIFT = 36;
  localparam int STEP_W  = 23;
  localparam int RPROD_W = PROD_W - DIV_PRE + RECIP_W;
  localparam int WIDE_W  = 25;

  // ceil(2^36 / 125): exact quotient for every 29-bit dividend.
  localparam logic [RECIP_W-1:0] RECIP_125 = 30'd549755814;

  localparam logic [CENTER_W-1:0]   CENTER_RST   = 12'd2048;
  localparam logic [DEADZONE_W-1:0] DEADZONE_RST = 11'd205;
  localparam logic [SPEED_W-1:0]    SPEED_RST    = 16'd3000;

  localparam logic signed [WIDE_W-1:0] PAN_LIMIT  = 25'sd18000;
  localparam logic signed [WIDE_W-1:0] TILT_LIMIT = 25'sd9000;
  localparam logic signed [WIDE_W-1:0] ROLL_LIMIT = 25'sd18000;

  localparam logic [MODE_W-1:0] MODE_PAN  = 2'd0;
  localparam logic [MODE_W-1:0] MODE_TILT = 2'd1;
  localparam logic [MODE_W-1:0] MODE_ROLL = 2'd2;

  localparam logic [CFG_INDEX_W-1:0] REG_CENTER     = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_DEADZONE   = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_SPEED      = 2'd2;

  typedef struct packed {
    logic              x_move;
    logic              x_pos;
    logic              y_move;
    logic              y_pos;
    logic              button;
    logic              clear;
    logic [PROD_W-1:0] product;
  } mul_stage_t;

  typedef struct packed {
    logic              x_move;
    logic              x_pos;
    logic              y_move;
    logic              y_pos;
    logic              button;
    logic              clear;
    logic [STEP_W-1:0] step;
  } step_stage_t;

  typedef struct packed {
    logic ld_mul;
    logic ld_step;
  } pipe_ctrl_t;

  function automatic logic signed [WIDE_W-1:0] sat_move(
    input logic signed [WIDE_W-1:0] angle,
    input logic                     up,
    input logic [STEP_W-1:0]        step,
    input logic signed [WIDE_W-1:0] limit
  );
    logic signed [WIDE_W-1:0] delta;
    logic signed [WIDE_W-1:0] next;
    delta = $signed(WIDE_W'(step));
    next  = up ? angle + delta : angle - delta;
    if (next > limit) begin
      next = limit;
    end else if (next < -limit) begin
      next = -limit;
    end
    return next;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/jgai_step_unit.sv =====
// ----------------------------------------------------------------------------
// Joystick gimbal step unit
// Deadzone decode and rate times time product, then the divide by 1000
// through a reciprocal multiply; two register stages.
// ----------------------------------------------------------------------------
`default_nettype none

module jgai_step_unit #(
  parameter int SAMPLE_BITS = jgai_pkg::SAMPLE_BITS_DEF
) (
  input  wire                                 clk,
  input  jgai_pkg::pipe_ctrl_t                ctrl,
  input  wire [SAMPLE_BITS-1:0]               x_sample,
  input  wire [SAMPLE_BITS-1:0]               y_sample,
  input  wire                                 button_pressed,
  input  wire [jgai_pkg::ELAPSED_W-1:0]       elapsed_ms,
  input  wire                                 clear_manual,
  input  wire [jgai_pkg::CENTER_W-1:0]        rest_center,
  input  wire [jgai_pkg::DEADZONE_W-1:0]      deadzone_counts,
  input  wire [jgai_pkg::SPEED_W-1:0]         speed_centideg_per_s,
  output jgai_pkg::step_stage_t               step_stage
);
  import jgai_pkg::*;

  localparam int CMP_W = ((SAMPLE_BITS > CENTER_W) ? SAMPLE_BITS : CENTER_W) + 1;

  mul_stage_t  mul_r;
  mul_stage_t  mul_nxt;
  step_stage_t step_r;
  step_stage_t step_nxt;
  logic [RPROD_W-1:0] rprod;

  function automatic logic [1:0] axis_decode(
    input logic [SAMPLE_BITS-1:0] raw,
    input logic [CENTER_W-1:0]    center,
    input logic [DEADZONE_W-1:0]  dz
  );
    logic signed [CMP_W-1:0] off;
    logic [CMP_W-1:0]        mag;
    off = $signed(CMP_W'(raw)) - $signed(CMP_W'(center));
    mag = off[CMP_W-1] ? $unsigned(-off) : $unsigned(off);
    return {mag > CMP_W'(dz), !off[CMP_W-1]};
  endfunction

  always_comb begin
    {mul_nxt.x_move, mul_nxt.x_pos} = axis_decode(x_sample, rest_center, deadzone_counts);
    {mul_nxt.y_move, mul_nxt.y_pos} = axis_decode(y_sample, rest_center, deadzone_counts);
    mul_nxt.button  = button_pressed;
    mul_nxt.clear   = clear_manual;
    mul_nxt.product = PROD_W'(speed_centideg_per_s) * PROD_W'(elapsed_ms);
  end

  assign rprod = RPROD_W'(mul_r.product[PROD_W-1:DIV_PRE]) * RPROD_W'(RECIP_125);

  always_comb begin
    step_nxt.x_move = mul_r.x_move;
    step_nxt.x_pos  = mul_r.x_pos;
    step_nxt.y_move = mul_r.y_move;
    step_nxt.y_pos  = mul_r.y_pos;
    step_nxt.button = mul_r.button;
    step_nxt.clear  = mul_r.clear;
    step_nxt.step   = rprod[DIV_SHIFT+STEP_W-1:DIV_SHIFT];
  end

  always_ff @(posedge clk) begin
    if (ctrl.ld_mul) begin
      mul_r <= mul_nxt;
    end
    if (ctrl.ld_step) begin
      step_r <= step_nxt;
    end
  end

  assign step_stage = step_r;

endmodule

`default_nettype wire

// ===== rtl/core/jgai_axis_state.sv =====
// ----------------------------------------------------------------------------
// Joystick gimbal axis state
// Mode cycling, sticky manual flag and saturating angle update; the state
// registers double as the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module jgai_axis_state (
  input  wire                              clk,
  input  wire                              rst_n,
  input  wire                              load,
  input  jgai_pkg::step_stage_t            step_stage,
  output logic signed [jgai_pkg::PAN_W-1:0]  pan_angle,
  output logic signed [jgai_pkg::TILT_W-1:0] tilt_angle,
  output logic signed [jgai_pkg::ROLL_W-1:0] bank_angle,
  output logic [jgai_pkg::MODE_W-1:0]        axis_mode,
  output logic                               manual_active
);
  import jgai_pkg::*;

  logic signed [PAN_W-1:0]  pan_r,  pan_nxt;
  logic signed [TILT_W-1:0] tilt_r, tilt_nxt;
  logic signed [ROLL_W-1:0] roll_r, roll_nxt;
  logic [MODE_W-1:0]        mode_r, mode_nxt;
  logic                     btn_was_r;
  logic                     manual_r, manual_nxt;

  always_comb begin
    pan_nxt    = pan_r;
    tilt_nxt   = tilt_r;
    roll_nxt   = roll_r;
    mode_nxt   = mode_r;
    manual_nxt = step_stage.clear ? 1'b0 : manual_r;
    if (step_stage.button && !btn_was_r) begin
      case (mode_r)
        MODE_PAN:  mode_nxt = MODE_TILT;
        MODE_TILT: mode_nxt = MODE_ROLL;
        default:   mode_nxt = MODE_PAN;
      endcase
    end
    case (mode_nxt)
      MODE_PAN: begin
        if (step_stage.x_move) begin
          pan_nxt = PAN_W'(sat_move(WIDE_W'(pan_r), step_stage.x_pos,
                                    step_stage.step, PAN_LIMIT));
          manual_nxt = 1'b1;
        end
      end
      MODE_TILT: begin
        if (step_stage.y_move) begin
          tilt_nxt = TILT_W'(sat_move(WIDE_W'(tilt_r), step_stage.y_pos,
                                      step_stage.step, TILT_LIMIT));
          manual_nxt = 1'b1;
        end
      end
      MODE_ROLL: begin
        if (step_stage.x_move) begin
          roll_nxt = ROLL_W'(sat_move(WIDE_W'(roll_r), step_stage.x_pos,
                                      step_stage.step, ROLL_LIMIT));
          manual_nxt = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pan_r     <= '0;
      tilt_r    <= '0;
      roll_r    <= '0;
      mode_r    <= MODE_PAN;
      btn_was_r <= 1'b1;
      manual_r  <= 1'b0;
    end else if (load) begin
      pan_r     <= pan_nxt;
      tilt_r    <= tilt_nxt;
      roll_r    <= roll_nxt;
      mode_r    <= mode_nxt;
      btn_was_r <= step_stage.button;
      manual_r  <= manual_nxt;
    end
  end

  assign pan_angle     = pan_r;
  assign tilt_angle    = tilt_r;
  assign bank_angle    = roll_r;
  assign axis_mode     = mode_r;
  assign manual_active = manual_r;

endmodule

`default_nettype wire

// ===== rtl/core/joystick_gimbal_angle_integrator_core.sv =====
// ----------------------------------------------------------------------------
// Joystick gimbal angle integrator core
// Path: a request passes the input, product, step and result registers in turn.
// Throughput: one request per cycle while the output is not stalled, through a four-register pipeline.
// The pipeline advances per stage, so bubbles close up while a result waits.
// Reset: synchronous; angles and mode zero, button taken as held, flag clear.
// ----------------------------------------------------------------------------
`default_nettype none

module joystick_gimbal_angle_integrator_core #(
  parameter int SAMPLE_BITS = jgai_pkg::SAMPLE_BITS_DEF,
  localparam int IN_W = ((2 * SAMPLE_BITS + 18 + 7) / 8) * 8
) (
  input  wire                               clk,
  input  wire                               rst_n,
  input  wire                               in_tvalid,
  output logic                              in_tready,
  // x_sample, y_sample, button_pressed, elapsed_ms, clear_manual, zero pad
  input  wire [IN_W-1:0]                    in_tdata,
  output logic                              out_tvalid,
  input  wire                               out_tready,
  // pan_angle, tilt_angle, roll angle, axis_mode, manual_active, zero pad
  output logic [jgai_pkg::OUT_W-1:0]        out_tdata,
  input  wire                               cfg_valid,
  output logic                              cfg_ready,
  input  wire [jgai_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  wire [jgai_pkg::CFG_DATA_W-1:0]    cfg_data
);
  import jgai_pkg::*;

  localparam int SB = SAMPLE_BITS;

  logic [CENTER_W-1:0]   center_r;
  logic [DEADZONE_W-1:0] deadzone_r;
  logic [SPEED_W-1:0]    speed_r;

  logic [SB-1:0]        x_r;
  logic [SB-1:0]        y_r;
  logic                 button_r;
  logic [ELAPSED_W-1:0] elapsed_r;
  logic                 clear_r;

  logic v_in_r, v_in_nxt;
  logic v_mul_r, v_mul_nxt;
  logic v_step_r, v_step_nxt;
  logic out_valid_r, out_valid_nxt;
  logic ld_out;
  logic accept;
  pipe_ctrl_t ctrl;
  step_stage_t step_stage;

  logic signed [PAN_W-1:0]  pan_angle;
  logic signed [TILT_W-1:0] tilt_angle;
  logic signed [ROLL_W-1:0] bank_angle;
  logic [MODE_W-1:0]        axis_mode;
  logic                     manual_active;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      center_r   <= CENTER_RST;
      deadzone_r <= DEADZONE_RST;
      speed_r    <= SPEED_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_CENTER:     center_r   <= cfg_data[CENTER_W-1:0];
        REG_DEADZONE:   deadzone_r <= cfg_data[DEADZONE_W-1:0];
        REG_SPEED:      speed_r    <= cfg_data[SPEED_W-1:0];
        default: begin
        end
      endcase
    end
  end

  assign ld_out       = v_step_r && (!out_valid_r || out_tready);
  assign ctrl.ld_step = v_mul_r && (!v_step_r || ld_out);
  assign ctrl.ld_mul  = v_in_r && (!v_mul_r || ctrl.ld_step);
  assign in_tready    = !v_in_r || ctrl.ld_mul;
  assign accept       = in_tvalid && in_tready;

  always_comb begin
    v_in_nxt      = accept ? 1'b1 : (ctrl.ld_mul ? 1'b0 : v_in_r);
    v_mul_nxt     = ctrl.ld_mul ? 1'b1 : (ctrl.ld_step ? 1'b0 : v_mul_r);
    v_step_nxt    = ctrl.ld_step ? 1'b1 : (ld_out ? 1'b0 : v_step_r);
    out_valid_nxt = ld_out ? 1'b1 : (out_tready ? 1'b0 : out_valid_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_in_r      <= 1'b0;
      v_mul_r     <= 1'b0;
      v_step_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      v_in_r      <= v_in_nxt;
      v_mul_r     <= v_mul_nxt;
      v_step_r    <= v_step_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      x_r       <= in_tdata[SB-1:0];
      y_r       <= in_tdata[2*SB-1:SB];
      button_r  <= in_tdata[2*SB];
      elapsed_r <= in_tdata[2*SB+ELAPSED_W:2*SB+1];
      clear_r   <= in_tdata[2*SB+ELAPSED_W+1];
    end
  end

  jgai_step_unit #(
    .SAMPLE_BITS(SAMPLE_BITS)
  ) u_step_unit (
    .clk                  (clk),
    .ctrl                 (ctrl),
    .x_sample             (x_r),
    .y_sample             (y_r),
    .button_pressed       (button_r),
    .elapsed_ms           (elapsed_r),
    .clear_manual         (clear_r),
    .rest_center          (center_r),
    .deadzone_counts      (deadzone_r),
    .speed_centideg_per_s (speed_r),
    .step_stage           (step_stage)
  );

  jgai_axis_state u_axis_state (
    .clk           (clk),
    .rst_n         (rst_n),
    .load          (ld_out),
    .step_stage    (step_stage),
    .pan_angle     (pan_angle),
    .tilt_angle    (tilt_angle),
    .bank_angle    (bank_angle),
    .axis_mode     (axis_mode),
    .manual_active (manual_active)
  );

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {6'd0, manual_active, axis_mode, bank_angle, tilt_angle, pan_angle};

endmodule

`default_nettype wire

// ===== rtl/core/jgai_checker.sv =====
// ----------------------------------------------------------------------------
// Joystick gimbal angle integrator checker
// Port-level assertions on the core, attached by a bind statement.
// ----------------------------------------------------------------------------
`default_nettype none
`include "joystick_gimbal_angle_integrator_core_defines.svh"

module jgai_checker (
  input wire                       clk,
  input wire                       rst_n,
  input wire                       out_tvalid,
  input wire                       out_tready,
  input wire [jgai_pkg::OUT_W-1:0] out_tdata
);
  import jgai_pkg::*;

  `JGAI_ASSERT_RST(a_rst_no_result, !rst_n |=> !out_tvalid, "result valid right after reset")
  `JGAI_ASSERT(a_stall_hold, out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata), "stalled result changed")
  `JGAI_ASSERT(a_mode_legal, out_tvalid |-> out_tdata[48:47] != 2'd3, "axis mode out of range")
  `JGAI_ASSERT(a_tilt_range, out_tvalid |-> $signed(out_tdata[30:16]) <= 15'sd9000 && $signed(out_tdata[30:16]) >= -15'sd9000, "tilt angle beyond its limit")

endmodule

bind joystick_gimbal_angle_integrator_core jgai_checker u_jgai_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

`default_nettype wire

// ===== verif/gimbal_pose_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Gimbal pose checker
// Watches the register, tick and pose channels of the angle integrator core.
// It keeps its own copy of the angles, the axis mode, the button history and
// the manual flag, predicts the pose that each accepted tick produces, and
// compares every returned pose field by field, in order, with the oldest one.
// ----------------------------------------------------------------------------
module gimbal_pose_checker #(
  parameter int IN_W = 48
) (
  input  wire                               clk,
  input  wire                               rst_n,
  input  wire                               in_tvalid,
  input  wire                               in_tready,
  input  wire [IN_W-1:0]                    in_tdata,
  input  wire                               out_tvalid,
  input  wire                               out_tready,
  input  wire [jgai_pkg::OUT_W-1:0]         out_tdata,
  input  wire                               cfg_valid,
  input  wire                               cfg_ready,
  input  wire [jgai_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  wire [jgai_pkg::CFG_DATA_W-1:0]    cfg_data,
  output int                                fail_count,
  output int                                pending
);
  import jgai_pkg::*;

  typedef struct {
    logic signed [PAN_W-1:0]  pan;
    logic signed [TILT_W-1:0] tilt;
    logic signed [ROLL_W-1:0] roll;
    logic [MODE_W-1:0]        mode;
    logic                     manual;
  } gimbal_pose_t;

  localparam int PAN_MAX  = 18000;
  localparam int TILT_MAX = 9000;
  localparam int ROLL_MAX = 18000;
  localparam longint MS_PER_S = 1000;

  gimbal_pose_t pose_q[$];

  logic [CENTER_W-1:0]   center;
  logic [DEADZONE_W-1:0] deadzone;
  logic [SPEED_W-1:0]    speed;

  int                pan_cd;
  int                tilt_cd;
  int                roll_cd;
  logic [MODE_W-1:0] axis_mode;
  logic              button_prev;
  logic              manual_flag;
  int                mismatches = 0;

  function automatic int stick_dir(input logic [11:0] sample);
    int offset;
    int mag;
    offset = int'(sample) - int'(center);
    mag = (offset < 0) ? -offset : offset;
    if (mag <= int'(deadzone)) begin
      return 0;
    end
    return (offset > 0) ? 1 : -1;
  endfunction

  function automatic int clamp_move(input int angle, input int dir, input int stride,
                                    input int limit);
    int next;
    next = (dir > 0) ? angle + stride : angle - stride;
    if (next > limit) begin
      next = limit;
    end
    if (next < -limit) begin
      next = -limit;
    end
    return next;
  endfunction

  task automatic advance_pose(input logic [IN_W-1:0] tick);
    int           dx;
    int           dy;
    int           stride;
    gimbal_pose_t pose;
    dx = stick_dir(tick[11:0]);
    dy = stick_dir(tick[23:12]);
    stride = int'((longint'(speed) * longint'(tick[40:25])) / MS_PER_S);
    if (tick[41]) begin
      manual_flag = 1'b0;
    end
    if (tick[24] && !button_prev) begin
      axis_mode = (axis_mode == MODE_ROLL) ? MODE_PAN : axis_mode + 1'b1;
    end
    button_prev = tick[24];
    if (axis_mode == MODE_PAN && dx != 0) begin
      pan_cd = clamp_move(pan_cd, dx, stride, PAN_MAX);
      manual_flag = 1'b1;
    end else if (axis_mode == MODE_TILT && dy != 0) begin
      tilt_cd = clamp_move(tilt_cd, dy, stride, TILT_MAX);
      manual_flag = 1'b1;
    end else if (axis_mode == MODE_ROLL && dx != 0) begin
      roll_cd = clamp_move(roll_cd, dx, stride, ROLL_MAX);
      manual_flag = 1'b1;
    end
    pose.pan    = pan_cd[PAN_W-1:0];
    pose.tilt   = tilt_cd[TILT_W-1:0];
    pose.roll   = roll_cd[ROLL_W-1:0];
    pose.mode   = axis_mode;
    pose.manual = manual_flag;
    pose_q.push_back(pose);
  endtask

  task automatic compare_pose(input logic [OUT_W-1:0] res);
    gimbal_pose_t want;
    gimbal_pose_t got;
    got.pan    = res[15:0];
    got.tilt   = res[30:16];
    got.roll   = res[46:31];
    got.mode   = res[48:47];
    got.manual = res[49];
    if (pose_q.size() == 0) begin
      mismatches++;
      if (mismatches <= 10) begin
        $display("unexpected pose: pan %0d tilt %0d roll %0d mode %0d manual %0d",
                 got.pan, got.tilt, got.roll, got.mode, got.manual);
      end
      return;
    end
    want = pose_q.pop_front();
    if (got.pan !== want.pan || got.tilt !== want.tilt || got.roll !== want.roll ||
        got.mode !== want.mode || got.manual !== want.manual) begin
      mismatches++;
      if (mismatches <= 10) begin
        $display("pose mismatch: expected pan %0d tilt %0d roll %0d mode %0d manual %0d",
                 want.pan, want.tilt, want.roll, want.mode, want.manual);
        $display("               actual   pan %0d tilt %0d roll %0d mode %0d manual %0d",
                 got.pan, got.tilt, got.roll, got.mode, got.manual);
      end
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      center      = CENTER_RST;
      deadzone    = DEADZONE_RST;
      speed       = SPEED_RST;
      pan_cd      = 0;
      tilt_cd     = 0;
      roll_cd     = 0;
      axis_mode   = MODE_PAN;
      button_prev = 1'b1;
      manual_flag = 1'b0;
      pose_q.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_CENTER:     center   = cfg_data[CENTER_W-1:0];
          REG_DEADZONE:   deadzone = cfg_data[DEADZONE_W-1:0];
          REG_SPEED:      speed    = cfg_data[SPEED_W-1:0];
          default: ;
        endcase
      end
      if (out_tvalid && out_tready) begin
        compare_pose(out_tdata);
      end
      if (in_tvalid && in_tready) begin
        advance_pose(in_tdata);
      end
    end
    fail_count <= mismatches;
    pending    <= pose_q.size();
  end

endmodule

// ===== verif/tb_joystick_gimbal_angle_integrator_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Joystick gimbal angle integrator core testbench
// Drives stick ticks and register writes into the core and lets the pose
// checker predict and compare every result. A directed pass covers the field
// extremes, deadzone edges, clamping, mode wrap and clear strobe handling;
// random phases under several register settings follow, with random gaps on
// both streams and one long output hold-off that backs up the pipeline.
// ----------------------------------------------------------------------------
module tb_joystick_gimbal_angle_integrator_core;
  import jgai_pkg::*;

  localparam int TICK_W = ((2 * SAMPLE_BITS_DEF + 18 + 7) / 8) * 8;
  localparam int PHASE_TICKS = 225;

  logic                   clk;
  logic                   rst_n;
  logic                   in_tvalid;
  logic                   in_tready;
  logic [TICK_W-1:0]      in_tdata;
  logic                   out_tvalid;
  logic                   out_tready;
  logic [OUT_W-1:0]       out_tdata;
  logic                   cfg_valid;
  logic                   cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;
  int                     fail_count;
  int                     pending;

  logic hold_req;
  logic hold_done;
  logic no_gaps;
  logic button_level;
  int   cur_center;
  int   cur_deadzone;

  joystick_gimbal_angle_integrator_core dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  gimbal_pose_checker #(.IN_W(TICK_W)) u_pose_chk (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .fail_count (fail_count),
    .pending    (pending)
  );

  initial begin
    clk = 1'b0;
  end

  always #6 clk = ~clk;

  initial begin
    #10_000_000;
    $display("joystick_gimbal_angle_integrator_core test failed");
    $finish;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (no_gaps || r < 50) begin
      return 0;
    end else if (r < 92) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(10, 40);
  endfunction

  task automatic send_tick(input int x, input int y, input bit btn, input int ms,
                           input bit clr);
    logic [TICK_W-1:0] tick;
    int                gap;
    tick = '0;
    tick[11:0]  = x[11:0];
    tick[23:12] = y[11:0];
    tick[24]    = btn;
    tick[40:25] = ms[15:0];
    tick[41]    = clr;
    in_tdata  <= tick;
    in_tvalid <= 1'b1;
    do @(posedge clk); while (!in_tready);
    gap = pick_gap();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic settle();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (8) @(posedge clk);
  endtask

  task automatic configure(input int center, input int deadzone, input int speed);
    logic [CFG_INDEX_W-1:0] idx[3];
    int                     val[3];
    idx[0] = REG_CENTER;
    idx[1] = REG_DEADZONE;
    idx[2] = REG_SPEED;
    val[0] = center;
    val[1] = deadzone;
    val[2] = speed;
    for (int i = 0; i < 3; i++) begin
      cfg_index <= idx[i];
      cfg_data  <= val[i][15:0];
      cfg_valid <= 1'b1;
      do @(posedge clk); while (!cfg_ready);
    end
    cfg_valid <= 1'b0;
    cur_center   = center;
    cur_deadzone = deadzone;
  endtask

  function automatic int stick_value();
    int r;
    int span;
    int v;
    r = $urandom_range(0, 99);
    span = cur_deadzone + 300;
    if (r < 12) begin
      v = $urandom_range(0, 1) ? 4095 : 0;
    end else if (r < 27) begin
      v = $urandom_range(0, 4095);
    end else if (r < 35) begin
      v = cur_center + ($urandom_range(0, 1) ? 1 : -1) * (cur_deadzone + $urandom_range(0, 1));
    end else begin
      v = cur_center + $urandom_range(0, 2 * span) - span;
    end
    if (v < 0) begin
      v = 0;
    end
    if (v > 4095) begin
      v = 4095;
    end
    return v;
  endfunction

  function automatic int elapsed_value();
    int r;
    r = $urandom_range(0, 99);
    if (r < 5) begin
      return 0;
    end else if (r < 65) begin
      return $urandom_range(0, 100);
    end else if (r < 90) begin
      return $urandom_range(100, 2000);
    end
    return $urandom_range(0, 65535);
  endfunction

  task automatic random_ticks(input int count, input bit with_hold);
    for (int i = 0; i < count; i++) begin
      if (i % 50 == 0) begin
        no_gaps = ($urandom_range(0, 3) == 0);
      end
      if (with_hold && i == count / 3) begin
        hold_req <= 1'b1;
        no_gaps = 1'b1;
      end
      if ($urandom_range(0, 99) < 12) begin
        button_level = ~button_level;
      end
      send_tick(stick_value(), stick_value(), button_level, elapsed_value(),
                $urandom_range(0, 99) < 10);
    end
  endtask

  initial begin
    int c;
    int d;
    rst_n        = 1'b0;
    in_tvalid    = 1'b0;
    in_tdata     = '0;
    cfg_valid    = 1'b0;
    cfg_index    = REG_CENTER;
    cfg_data     = '0;
    hold_req     = 1'b0;
    no_gaps      = 1'b0;
    button_level = 1'b0;
    cur_center   = 2048;
    cur_deadzone = 205;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Button held out of reset is not a press; then deadzone edges and clamps.
    send_tick(2048, 2048, 1'b1, 0, 1'b0);
    send_tick(4095, 2048, 1'b0, 1000, 1'b0);
    send_tick(0, 4095, 1'b0, 65535, 1'b0);
    send_tick(4095, 0, 1'b0, 65535, 1'b0);
    send_tick(2253, 2048, 1'b0, 500, 1'b0);
    send_tick(1843, 2048, 1'b0, 500, 1'b1);
    send_tick(1842, 2048, 1'b0, 0, 1'b0);
    send_tick(2254, 2048, 1'b0, 1, 1'b1);
    send_tick(2048, 2048, 1'b0, 43690, 1'b1);
    send_tick(12'hAAA, 12'h555, 1'b1, 65535, 1'b0);
    send_tick(12'h555, 4095, 1'b1, 65535, 1'b1);
    send_tick(2048, 0, 1'b1, 21845, 1'b0);
    send_tick(2048, 0, 1'b0, 65535, 1'b0);
    send_tick(4095, 2048, 1'b1, 65535, 1'b0);
    send_tick(0, 2048, 1'b1, 333, 1'b1);
    send_tick(2048, 2048, 1'b0, 0, 1'b1);
    send_tick(4095, 4095, 1'b1, 7, 1'b0);
    settle();

    // Products under one unit still count as a move.
    configure(2048, 205, 1);
    send_tick(4095, 2048, 1'b0, 999, 1'b1);
    send_tick(0, 2048, 1'b0, 65535, 1'b0);
    settle();

    // Zero deadzone at the low extreme center, full speed.
    configure(0, 0, 65535);
    send_tick(0, 0, 1'b0, 65535, 1'b1);
    send_tick(1, 0, 1'b0, 1, 1'b0);
    send_tick(4095, 1, 1'b1, 65535, 1'b0);
    settle();

    for (int p = 0; p < 6; p++) begin
      case (p)
        0: configure(2048, 205, 3000);
        1: configure($urandom_range(0, 4095), $urandom_range(0, 400), $urandom_range(0, 65535));
        2: configure(0, 0, 65535);
        3: configure(4095, 2047, 0);
        4: begin
          c = $urandom_range(600, 3500);
          d = $urandom_range(0, 500);
          configure(c, d, $urandom_range(1000, 65535));
        end
        default: configure($urandom_range(0, 4095), $urandom_range(0, 64),
                           $urandom_range(1, 100));
      endcase
      random_ticks(PHASE_TICKS, p == 4);
      settle();
    end

    if (fail_count == 0 && pending == 0) begin
      $display("joystick_gimbal_angle_integrator_core test passed");
    end else begin
      $display("joystick_gimbal_angle_integrator_core test failed");
    end
    $finish;
  end

  initial begin
    int run;
    int stall;
    int r;
    out_tready = 1'b0;
    hold_done  = 1'b0;
    while (!rst_n) @(posedge clk);
    forever begin
      if (hold_req && !hold_done) begin
        hold_done = 1'b1;
        out_tready <= 1'b0;
        repeat (400) @(posedge clk);
      end
      run = $urandom_range(1, 24);
      out_tready <= 1'b1;
      repeat (run) @(posedge clk);
      r = $urandom_range(0, 99);
      stall = (r < 55) ? 0 : (r < 92) ? $urandom_range(1, 3) : $urandom_range(10, 40);
      if (stall > 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
    end
  end

endmodule
